/* hw/rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // width of the payload length counter, 16 to 64
  localparam int LENGTH_BITS = 64;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam int KEY_BYTES = 4;

  // extension and key byte counts, minus one
  localparam logic [2:0] EXT_CNT_16  = 3'd1;
  localparam logic [2:0] EXT_CNT_64  = 3'd7;
  localparam logic [2:0] KEY_CNT     = 3'(KEY_BYTES - 1);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic [3:0] frame_opcode_out;
    logic       final_fragment;
    logic       frame_end;
    logic       was_masked;
  } result_t;

endpackage

/* hw/rtl/wsd_in_if.sv */
// ----------------------------------------------------------------------------
// wsd_in_if
// Raw byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/wsd_out_if.sv */
// ----------------------------------------------------------------------------
// wsd_out_if
// Payload result channel out of the deframer.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_data;
  logic [3:0] frame_opcode_out;
  logic       final_fragment;
  logic       frame_end;
  logic       was_masked;

  modport source (output valid, output payload_byte, output has_data,
                  output frame_opcode_out, output final_fragment,
                  output frame_end, output was_masked, input ready);
  modport sink   (input valid, input payload_byte, input has_data,
                  input frame_opcode_out, input final_fragment,
                  input frame_end, input was_masked, output ready);
endinterface

/* hw/rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasking; one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);

  localparam int LEN_W = wsd_pkg::LENGTH_BITS;

  wsd_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic              fin_r, fin_nxt;
  logic              masked_r, masked_nxt;

  logic [LEN_W-1:0]  len_shift;
  logic [LEN_W-1:0]  len_final;
  logic [LEN_W-1:0]  len_dec;
  logic              ovf_acc;
  logic [7:0]        key_byte;
  logic [7:0]        data;
  logic              emit;
  logic              emit_has;
  logic              emit_end;
  logic [7:0]        emit_data;

  always_comb begin
    len_shift = {len_r[LEN_W-9:0], in_byte};
    ovf_acc   = ovf_r | (len_r[LEN_W-1 -: 8] != 8'd0);
    len_final = ovf_acc ? {LEN_W{1'b1}} : len_shift;
    len_dec   = (len_r != '0) ? len_r - LEN_W'(1) : len_r;
    key_byte  = key_r[{~idx_r, 3'b000} +: 8];
    data      = masked_r ? (in_byte ^ key_byte) : in_byte;
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    masked_nxt = masked_r;
    emit       = 1'b0;
    emit_has   = 1'b0;
    emit_end   = 1'b0;
    emit_data  = 8'd0;

    unique case (phase_r)
      wsd_pkg::PH_HDR1: begin
        masked_nxt = in_byte[7];
        idx_nxt    = 2'd0;
        ovf_nxt    = 1'b0;
        len_nxt    = '0;
        if (in_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
          phase_nxt = wsd_pkg::PH_EXT;
          cnt_nxt   = wsd_pkg::EXT_CNT_16;
        end else if (in_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
          phase_nxt = wsd_pkg::PH_EXT;
          cnt_nxt   = wsd_pkg::EXT_CNT_64;
        end else begin
          len_nxt = LEN_W'(in_byte[6:0]);
          if (in_byte[7]) begin
            phase_nxt = wsd_pkg::PH_KEY;
            cnt_nxt   = wsd_pkg::KEY_CNT;
            key_nxt   = 32'd0;
          end else if (in_byte[6:0] == 7'd0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
            emit      = 1'b1;
            emit_end  = 1'b1;
          end else begin
            phase_nxt = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_EXT: begin
        if (cnt_r != 3'd0) begin
          cnt_nxt = cnt_r - 3'd1;
          len_nxt = len_shift;
          ovf_nxt = ovf_acc;
        end else begin
          len_nxt = len_final;
          if (masked_r) begin
            phase_nxt = wsd_pkg::PH_KEY;
            cnt_nxt   = wsd_pkg::KEY_CNT;
            key_nxt   = 32'd0;
          end else if (len_final == '0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
            emit      = 1'b1;
            emit_end  = 1'b1;
          end else begin
            phase_nxt = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_nxt = {key_r[23:0], in_byte};
        if (cnt_r != 3'd0) begin
          cnt_nxt = cnt_r - 3'd1;
        end else if (len_r == '0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
          emit      = 1'b1;
          emit_end  = 1'b1;
        end else begin
          phase_nxt = wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_DATA: begin
        idx_nxt   = idx_r + 2'd1;
        len_nxt   = len_dec;
        emit      = 1'b1;
        emit_has  = 1'b1;
        emit_data = data;
        emit_end  = (len_dec == '0);
        if (len_dec == '0) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        // first header byte, also for unused phase codes
        fin_nxt    = in_byte[7];
        opcode_nxt = in_byte[3:0];
        phase_nxt  = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  always_comb begin
    res_valid            = step & emit;
    res.payload_byte     = emit_data;
    res.has_data         = emit_has;
    res.frame_opcode_out = opcode_nxt;
    res.final_fragment   = fin_nxt;
    res.frame_end        = emit_end;
    res.was_masked       = masked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      cnt_r    <= 3'd0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      masked_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      masked_r <= masked_nxt;
    end
  end

endmodule

/* hw/rtl/websocket_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Each result item is registered in the output stage, or in the skid stage while the output is held.
// Throughput: one byte per cycle while in_ready is high; set by the single-pass parser update.
// in_ready drops only while the two-entry output (register plus skid) is full.
// Reset: synchronous, active low; parser expects a first header byte, output
// and skid stage empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);

  logic             step;
  logic             res_valid;
  wsd_pkg::result_t res;

  logic             out_valid_r;
  wsd_pkg::result_t out_r;
  logic             skid_valid_r;
  wsd_pkg::result_t skid_r;
  logic             pop;

  assign in_ch.ready = ~skid_valid_r;
  assign step        = in_ch.valid & ~skid_valid_r;
  assign pop         = out_valid_r & out_ch.ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (in_ch.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        // output still held, park the new item
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.payload_byte     = out_r.payload_byte;
  assign out_ch.has_data         = out_r.has_data;
  assign out_ch.frame_opcode_out = out_r.frame_opcode_out;
  assign out_ch.final_fragment   = out_r.final_fragment;
  assign out_ch.frame_end        = out_r.frame_end;
  assign out_ch.was_masked       = out_r.was_masked;

endmodule
